[hw/rtl/rtt_pkg.sv]
// Package for the RTT estimator: field widths, register indexes, reset gains,
// and the small structs passed between the front end, queue and back end.
// No dependencies.
package rtt_pkg;

    localparam int TIME_BITS_DEF = 48;
    localparam int SEC_BITS      = 32;
    localparam int NS_BITS       = 30;
    localparam int GAIN_BITS     = 16;
    localparam int CFG_IDX_BITS  = 8;
    localparam int QUEUE_DEPTH   = 2;

    localparam logic [NS_BITS:0] NS_PER_SEC = 31'd1000000000;

    localparam logic [CFG_IDX_BITS-1:0] REG_ALPHA = 8'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_BETA  = 8'd1;

    localparam logic [GAIN_BITS-1:0] ALPHA_RESET = 16'd8192;
    localparam logic [GAIN_BITS-1:0] BETA_RESET  = 16'd16384;

    typedef struct packed {
        logic positive;
        logic nonneg;
    } rtt_flags_t;

    typedef struct packed {
        logic full;
        logic empty;
    } rtt_qstat_t;

endpackage

[hw/rtl/rtt_if.sv]
// Handshake interfaces for the RTT estimator: timestamp input, result output
// and configuration write channel. Depends on rtt_pkg.
interface rtt_in_if;
    logic                          valid;
    logic                          ready;
    logic [rtt_pkg::SEC_BITS-1:0]  send_seconds;
    logic [rtt_pkg::NS_BITS-1:0]   send_nanos;
    logic [rtt_pkg::SEC_BITS-1:0]  recv_seconds;
    logic [rtt_pkg::NS_BITS-1:0]   recv_nanos;

    modport source (output valid, send_seconds, send_nanos, recv_seconds, recv_nanos,
                    input ready);
    modport sink   (input valid, send_seconds, send_nanos, recv_seconds, recv_nanos,
                    output ready);
endinterface

interface rtt_out_if #(parameter int TIME_BITS = rtt_pkg::TIME_BITS_DEF);
    logic                 valid;
    logic                 ready;
    logic [TIME_BITS-1:0] sample_ns;
    logic [TIME_BITS-1:0] smoothed_ns;
    logic [TIME_BITS-1:0] deviation_ns;
    logic [TIME_BITS-1:0] threshold_ns;
    logic                 timed_out;

    modport source (output valid, sample_ns, smoothed_ns, deviation_ns, threshold_ns,
                    timed_out, input ready);
    modport sink   (input valid, sample_ns, smoothed_ns, deviation_ns, threshold_ns,
                    timed_out, output ready);
endinterface

interface rtt_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [rtt_pkg::CFG_IDX_BITS-1:0] index;
    logic [rtt_pkg::GAIN_BITS-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[hw/rtl/rtt_front.sv]
// Front end: two-stage pipeline forming the signed round-trip sample in ns
// and classifying it (positive, non-negative, saturated). Depends on rtt_pkg, rtt_if.
module rtt_front #(
    parameter int TIME_BITS = rtt_pkg::TIME_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    rtt_in_if.sink               sample_ch,
    input  rtt_pkg::rtt_qstat_t  q_stat,
    output logic                 push,
    output logic [TIME_BITS-1:0] push_sample,
    output rtt_pkg::rtt_flags_t  push_flags
);

    localparam logic [63:0]          TIME_MAX64 = {64{1'b1}} >> (64 - TIME_BITS);
    localparam logic [TIME_BITS-1:0] TIME_MAX   = {TIME_BITS{1'b1}};

    logic                           s1_valid_reg, s1_valid_next;
    logic                           s2_valid_reg, s2_valid_next;
    logic signed [rtt_pkg::SEC_BITS:0] d_sec_reg;
    logic signed [rtt_pkg::NS_BITS:0]  d_ns_reg, d_ns2_reg;
    logic signed [63:0]             prod_reg;
    logic signed [63:0]             raw;
    logic                           s1_move;
    logic                           saturate;

    assign push    = s2_valid_reg && !q_stat.full;
    assign s1_move = s1_valid_reg && (!s2_valid_reg || push);
    assign sample_ch.ready = !s1_valid_reg || s1_move;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        s2_valid_next = s2_valid_reg;
        if (push)
        begin
            s2_valid_next = 1'b0;
        end
        if (s1_move)
        begin
            s1_valid_next = 1'b0;
            s2_valid_next = 1'b1;
        end
        if (sample_ch.valid && sample_ch.ready)
        begin
            s1_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample_ch.valid && sample_ch.ready)
        begin
            d_sec_reg <= $signed({1'b0, sample_ch.recv_seconds})
                       - $signed({1'b0, sample_ch.send_seconds});
            d_ns_reg  <= $signed({1'b0, sample_ch.recv_nanos})
                       - $signed({1'b0, sample_ch.send_nanos});
        end
        if (s1_move)
        begin
            // |d_sec| < 2^32 and 1e9 < 2^30, so 64 bits hold the product
            prod_reg  <= 64'(d_sec_reg * $signed(rtt_pkg::NS_PER_SEC));
            d_ns2_reg <= d_ns_reg;
        end
    end

    assign raw      = prod_reg + 64'(d_ns2_reg);
    assign saturate = $unsigned(raw) > TIME_MAX64;

    always_comb
    begin
        push_flags.nonneg   = !raw[63];
        push_flags.positive = !raw[63] && (raw != 64'sd0);
        if (!push_flags.positive)
        begin
            push_sample = '0;
        end
        else if (saturate)
        begin
            push_sample = TIME_MAX;
        end
        else
        begin
            push_sample = raw[TIME_BITS-1:0];
        end
    end

endmodule

[hw/rtl/rtt_queue.sv]
// Short FIFO between front and back end, holding classified samples.
// Depends on rtt_pkg.
module rtt_queue #(
    parameter int WIDTH = rtt_pkg::TIME_BITS_DEF + 2,
    parameter int DEPTH = rtt_pkg::QUEUE_DEPTH
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  logic [WIDTH-1:0]    push_data,
    input  logic                pop,
    output logic [WIDTH-1:0]    pop_data,
    output rtt_pkg::rtt_qstat_t stat
);

    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]    mem [DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0] count_reg, count_next;

    assign stat.full  = (count_reg == CNT_BITS'(DEPTH));
    assign stat.empty = (count_reg == '0);
    assign pop_data   = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[hw/rtl/rtt_back.sv]
// Back end: sequencer updating smoothed RTT, deviation and timeout limit with
// one shared 16x32 gain multiplier; holds the gain registers and the result
// register. Depends on rtt_pkg, rtt_if.
module rtt_back #(
    parameter int TIME_BITS = rtt_pkg::TIME_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    rtt_cfg_if.sink              cfg_ch,
    input  rtt_pkg::rtt_qstat_t  q_stat,
    input  logic [TIME_BITS-1:0] q_sample,
    input  rtt_pkg::rtt_flags_t  q_flags,
    output logic                 pop,
    rtt_out_if.source            result_ch
);

    localparam int ACC_W = TIME_BITS + rtt_pkg::GAIN_BITS;
    localparam int MUL_W = rtt_pkg::GAIN_BITS + 32;
    localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_EST   = 4'd1;
    localparam logic [3:0] ST_MLO   = 4'd2;
    localparam logic [3:0] ST_MHI   = 4'd3;
    localparam logic [3:0] ST_APPLY = 4'd4;
    localparam logic [3:0] ST_ERR   = 4'd5;
    localparam logic [3:0] ST_DEV   = 4'd6;
    localparam logic [3:0] ST_THR   = 4'd7;
    localparam logic [3:0] ST_DONE  = 4'd8;

    logic [3:0]                    state_reg, state_next;
    logic [rtt_pkg::GAIN_BITS-1:0] alpha_reg, alpha_next;
    logic [rtt_pkg::GAIN_BITS-1:0] beta_reg, beta_next;
    logic [TIME_BITS-1:0]          smoothed_reg, smoothed_next;
    logic [TIME_BITS-1:0]          dev_reg, dev_next;
    logic [TIME_BITS-1:0]          limit_reg, limit_next;
    logic [TIME_BITS-1:0]          sample_reg, sample_next;
    rtt_pkg::rtt_flags_t           flags_reg, flags_next;
    logic [TIME_BITS-1:0]          opd_reg, opd_next;
    logic [TIME_BITS-1:0]          err_reg, err_next;
    logic                          up_reg, up_next;
    logic                          sel_reg, sel_next;
    logic [ACC_W-1:0]              acc_reg, acc_next;
    logic                          out_valid_reg, out_valid_next;
    logic [TIME_BITS-1:0]          o_sample_reg, o_smoothed_reg, o_dev_reg, o_limit_reg;
    logic                          o_fired_reg;
    logic                          load_out;

    logic [63:0]                   opd64;
    logic [31:0]                   mul_b;
    logic [MUL_W-1:0]              prod;
    logic [rtt_pkg::GAIN_BITS-1:0] gain;
    logic [TIME_BITS-1:0]          step;
    logic [TIME_BITS:0]            thr_sum;
    logic                          dev_big;

    assign cfg_ch.ready = 1'b1;

    // one multiplier, low then high 32-bit half of the operand
    assign opd64 = 64'(opd_reg);
    assign mul_b = (state_reg == ST_MHI) ? opd64[63:32] : opd64[31:0];
    assign gain  = sel_reg ? beta_reg : alpha_reg;
    assign prod  = MUL_W'(gain) * MUL_W'(mul_b);
    assign step  = acc_reg[rtt_pkg::GAIN_BITS +: TIME_BITS];

    assign dev_big = (dev_reg[TIME_BITS-1 -: 2] != 2'b00);
    assign thr_sum = {1'b0, dev_reg << 2} + {1'b0, smoothed_reg};

    always_comb
    begin
        state_next     = state_reg;
        alpha_next     = alpha_reg;
        beta_next      = beta_reg;
        smoothed_next  = smoothed_reg;
        dev_next       = dev_reg;
        limit_next     = limit_reg;
        sample_next    = sample_reg;
        flags_next     = flags_reg;
        opd_next       = opd_reg;
        err_next       = err_reg;
        up_next        = up_reg;
        sel_next       = sel_reg;
        acc_next       = acc_reg;
        out_valid_next = out_valid_reg;
        pop            = 1'b0;
        load_out       = 1'b0;

        if (cfg_ch.valid)
        begin
            priority if (cfg_ch.index == rtt_pkg::REG_ALPHA)
            begin
                alpha_next = cfg_ch.data;
            end
            else if (cfg_ch.index == rtt_pkg::REG_BETA)
            begin
                beta_next = cfg_ch.data;
            end
            else
            begin
                // other indexes are accepted and ignored
                alpha_next = alpha_reg;
            end
        end

        if (out_valid_reg && result_ch.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    pop         = 1'b1;
                    sample_next = q_sample;
                    flags_next  = q_flags;
                    state_next  = ST_EST;
                end
            end
            ST_EST:
            begin
                if (!flags_reg.positive)
                begin
                    state_next = ST_DONE;
                end
                else if (smoothed_reg == '0)
                begin
                    smoothed_next = sample_reg;
                    dev_next      = sample_reg >> 1;
                    state_next    = ST_THR;
                end
                else
                begin
                    up_next    = (sample_reg >= smoothed_reg);
                    opd_next   = (sample_reg >= smoothed_reg) ? sample_reg - smoothed_reg
                                                              : smoothed_reg - sample_reg;
                    sel_next   = 1'b0;
                    state_next = ST_MLO;
                end
            end
            ST_MLO:
            begin
                acc_next   = ACC_W'(prod);
                state_next = ST_MHI;
            end
            ST_MHI:
            begin
                acc_next   = acc_reg + ACC_W'({prod, 32'b0});
                state_next = ST_APPLY;
            end
            ST_APPLY:
            begin
                if (!sel_reg)
                begin
                    smoothed_next = up_reg ? smoothed_reg + step : smoothed_reg - step;
                    state_next    = ST_ERR;
                end
                else
                begin
                    dev_next   = up_reg ? dev_reg + step : dev_reg - step;
                    state_next = ST_THR;
                end
            end
            ST_ERR:
            begin
                err_next   = (sample_reg >= smoothed_reg) ? sample_reg - smoothed_reg
                                                          : smoothed_reg - sample_reg;
                state_next = ST_DEV;
            end
            ST_DEV:
            begin
                up_next    = (err_reg >= dev_reg);
                opd_next   = (err_reg >= dev_reg) ? err_reg - dev_reg : dev_reg - err_reg;
                sel_next   = 1'b1;
                state_next = ST_MLO;
            end
            ST_THR:
            begin
                if ((dev_reg != '0) && (smoothed_reg != '0))
                begin
                    limit_next = (dev_big || thr_sum[TIME_BITS]) ? TIME_MAX
                                                                 : thr_sum[TIME_BITS-1:0];
                end
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || result_ch.ready)
                begin
                    load_out       = 1'b1;
                    out_valid_next = 1'b1;
                    if (!q_stat.empty)
                    begin
                        pop         = 1'b1;
                        sample_next = q_sample;
                        flags_next  = q_flags;
                        state_next  = ST_EST;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            alpha_reg     <= rtt_pkg::ALPHA_RESET;
            beta_reg      <= rtt_pkg::BETA_RESET;
            smoothed_reg  <= '0;
            dev_reg       <= '0;
            limit_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            alpha_reg     <= alpha_next;
            beta_reg      <= beta_next;
            smoothed_reg  <= smoothed_next;
            dev_reg       <= dev_next;
            limit_reg     <= limit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sample_reg <= sample_next;
        flags_reg  <= flags_next;
        opd_reg    <= opd_next;
        err_reg    <= err_next;
        up_reg     <= up_next;
        sel_reg    <= sel_next;
        acc_reg    <= acc_next;
        if (load_out)
        begin
            o_sample_reg   <= sample_reg;
            o_smoothed_reg <= smoothed_reg;
            o_dev_reg      <= dev_reg;
            o_limit_reg    <= limit_reg;
            o_fired_reg    <= flags_reg.nonneg && (sample_reg >= limit_reg);
        end
    end

    assign result_ch.valid        = out_valid_reg;
    assign result_ch.sample_ns    = o_sample_reg;
    assign result_ch.smoothed_ns  = o_smoothed_reg;
    assign result_ch.deviation_ns = o_dev_reg;
    assign result_ch.threshold_ns = o_limit_reg;
    assign result_ch.timed_out    = o_fired_reg;

endmodule

[hw/rtl/rtt_estimator_timeout_core.sv]
// RTT estimator with timeout threshold. The back-end sequencer leaves the estimate
// as is for non-positive samples, sets it from the first sample and updates it for
// later ones with two passes of the shared 16x32 gain multiplier. It takes one item
// at a time; the front end and queue go on accepting samples until the queue fills.
// Reset: estimate, deviation and limit clear to zero, gains to 8192 and 16384.
module rtt_estimator_timeout_core #(
    parameter int TIME_BITS = rtt_pkg::TIME_BITS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    rtt_in_if.sink    sample_ch,
    rtt_cfg_if.sink   cfg_ch,
    rtt_out_if.source result_ch
);

    localparam int Q_WIDTH = TIME_BITS + $bits(rtt_pkg::rtt_flags_t);

    rtt_pkg::rtt_qstat_t  q_stat;
    logic                 push, pop;
    logic [TIME_BITS-1:0] push_sample, q_sample;
    rtt_pkg::rtt_flags_t  push_flags, q_flags;
    logic [Q_WIDTH-1:0]   q_rd;

    rtt_front #(.TIME_BITS(TIME_BITS)) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .sample_ch   (sample_ch),
        .q_stat      (q_stat),
        .push        (push),
        .push_sample (push_sample),
        .push_flags  (push_flags)
    );

    rtt_queue #(.WIDTH(Q_WIDTH), .DEPTH(rtt_pkg::QUEUE_DEPTH)) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data ({push_flags, push_sample}),
        .pop       (pop),
        .pop_data  (q_rd),
        .stat      (q_stat)
    );

    assign q_sample = q_rd[TIME_BITS-1:0];
    assign q_flags  = q_rd[Q_WIDTH-1:TIME_BITS];

    rtt_back #(.TIME_BITS(TIME_BITS)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_ch    (cfg_ch),
        .q_stat    (q_stat),
        .q_sample  (q_sample),
        .q_flags   (q_flags),
        .pop       (pop),
        .result_ch (result_ch)
    );

endmodule

[hw/rtl/rtt_chk.sv]
// Port-level checks for the RTT estimator core, bound to the top level.
// Depends on rtt_pkg.
module rtt_chk #(
    parameter int TIME_BITS = rtt_pkg::TIME_BITS_DEF
) (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_ready,
    input logic                 out_valid,
    input logic                 out_ready,
    input logic [TIME_BITS-1:0] sample_ns,
    input logic [TIME_BITS-1:0] smoothed_ns,
    input logic [TIME_BITS-1:0] threshold_ns,
    input logic                 timed_out
);

    // two front stages, the queue, one item in the back end, the result register
    localparam int MAX_INFLIGHT = 4 + rtt_pkg::QUEUE_DEPTH;
    localparam int CNT_BITS     = $clog2(MAX_INFLIGHT + 2);

    logic [CNT_BITS-1:0] inflight_reg, inflight_next;

    always_comb
    begin
        inflight_next = inflight_reg;
        if ((in_valid && in_ready) && !(out_valid && out_ready))
        begin
            inflight_next = inflight_reg + 1'b1;
        end
        else if (!(in_valid && in_ready) && (out_valid && out_ready))
        begin
            inflight_next = inflight_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inflight_reg <= '0;
        end
        else
        begin
            inflight_reg <= inflight_next;
        end
    end

    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (inflight_reg != '0))
        else $error("result shown with no item outstanding");

    a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        inflight_reg <= CNT_BITS'(MAX_INFLIGHT))
        else $error("more items in flight than the design can hold");

    a_fired: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && timed_out) |-> (sample_ns >= threshold_ns))
        else $error("timeout flagged below threshold");

    a_estimate: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (sample_ns != '0)) |-> (smoothed_ns != '0))
        else $error("positive sample left no estimate");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(sample_ns)
                                       && $stable(threshold_ns)))
        else $error("stalled result changed");

endmodule

bind rtt_estimator_timeout_core rtt_chk #(.TIME_BITS(TIME_BITS)) u_rtt_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (sample_ch.valid),
    .in_ready     (sample_ch.ready),
    .out_valid    (result_ch.valid),
    .out_ready    (result_ch.ready),
    .sample_ns    (result_ch.sample_ns),
    .smoothed_ns  (result_ch.smoothed_ns),
    .threshold_ns (result_ch.threshold_ns),
    .timed_out    (result_ch.timed_out)
);

[sim/rtt_checker.sv]
// Checker for the RTT estimator: watches the sample, config and result channels,
// predicts each result from the accepted timestamps and compares field by field.
// Depends on rtt_pkg and the channel interfaces in rtt_if.sv.
module rtt_checker (
    input  logic clk,
    input  logic rst_n,
    rtt_in_if    sample_mon,
    rtt_cfg_if   cfg_mon,
    rtt_out_if   result_mon,
    output int   fail_count,
    output int   outstanding,
    output int   checked_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          TB_BITS  = rtt_pkg::TIME_BITS_DEF;
    localparam int          G_BITS   = rtt_pkg::GAIN_BITS;
    localparam logic [63:0] TIME_MAX = (64'd1 << TB_BITS) - 64'd1;
    localparam longint      NS_PER_S = 1000000000;

    typedef struct packed {
        logic [TB_BITS-1:0] sample_ns;
        logic [TB_BITS-1:0] smoothed_ns;
        logic [TB_BITS-1:0] deviation_ns;
        logic [TB_BITS-1:0] threshold_ns;
        logic               timed_out;
    } rtt_result_t;

    rtt_result_t expected_results[$];

    logic [G_BITS-1:0] alpha_q  = rtt_pkg::ALPHA_RESET;
    logic [G_BITS-1:0] beta_q   = rtt_pkg::BETA_RESET;
    logic [63:0]       srtt_q   = '0;
    logic [63:0]       rttvar_q = '0;
    logic [63:0]       limit_q  = '0;

    // floor(g * d / 65536), split so the product stays inside 64 bits
    function automatic logic [63:0] scale_by_gain(logic [G_BITS-1:0] g, logic [63:0] d);
        logic [63:0] g64;
        g64 = {48'd0, g};
        return g64 * (d >> 16) + ((g64 * (d & 64'hFFFF)) >> 16);
    endfunction

    // move from old toward target by a gain-weighted step, truncated toward old
    function automatic logic [63:0] step_toward(logic [63:0] old, logic [63:0] target,
                                                logic [G_BITS-1:0] g);
        if (target >= old)
            return old + scale_by_gain(g, target - old);
        return old - scale_by_gain(g, old - target);
    endfunction

    task automatic predict_rtt(input logic [rtt_pkg::SEC_BITS-1:0] ss,
                               input logic [rtt_pkg::NS_BITS-1:0]  sn,
                               input logic [rtt_pkg::SEC_BITS-1:0] rs,
                               input logic [rtt_pkg::NS_BITS-1:0]  rn,
                               output rtt_result_t r);
        longint      raw;
        logic [63:0] sample;
        logic [63:0] err;
        logic [63:0] t;
        raw = (longint'(rs) - longint'(ss)) * NS_PER_S + (longint'(rn) - longint'(sn));
        sample = '0;
        if (raw > 0)
        begin
            sample = 64'(raw);
            if (sample > TIME_MAX)
                sample = TIME_MAX;
            if (srtt_q == 0)
            begin
                srtt_q   = sample;
                rttvar_q = sample >> 1;
            end
            else
            begin
                srtt_q   = step_toward(srtt_q, sample, alpha_q);
                err      = (sample >= srtt_q) ? sample - srtt_q : srtt_q - sample;
                rttvar_q = step_toward(rttvar_q, err, beta_q);
            end
            // threshold only moves once both estimate and deviation are non-zero
            if (rttvar_q > 0 && srtt_q > 0)
            begin
                if (rttvar_q > TIME_MAX / 4)
                    limit_q = TIME_MAX;
                else
                begin
                    t = rttvar_q * 4;
                    limit_q = (t > TIME_MAX - srtt_q) ? TIME_MAX : t + srtt_q;
                end
            end
        end
        r.sample_ns    = sample[TB_BITS-1:0];
        r.smoothed_ns  = srtt_q[TB_BITS-1:0];
        r.deviation_ns = rttvar_q[TB_BITS-1:0];
        r.threshold_ns = limit_q[TB_BITS-1:0];
        r.timed_out    = (raw >= 0) && (sample >= limit_q);
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t mismatch: %s got %h want %h", $realtime, what, got, want);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : monitor
        rtt_result_t got;
        rtt_result_t want;
        if (!rst_n)
        begin
            alpha_q       = rtt_pkg::ALPHA_RESET;
            beta_q        = rtt_pkg::BETA_RESET;
            srtt_q        = '0;
            rttvar_q      = '0;
            limit_q       = '0;
            fail_count    = 0;
            checked_count = 0;
            expected_results.delete();
            outstanding <= 0;
        end
        else
        begin
            if (cfg_mon.valid && cfg_mon.ready)
            begin
                if (cfg_mon.index == rtt_pkg::REG_ALPHA)
                    alpha_q = cfg_mon.data;
                else if (cfg_mon.index == rtt_pkg::REG_BETA)
                    beta_q = cfg_mon.data;
            end
            if (result_mon.valid && result_mon.ready)
            begin
                got.sample_ns    = result_mon.sample_ns;
                got.smoothed_ns  = result_mon.smoothed_ns;
                got.deviation_ns = result_mon.deviation_ns;
                got.threshold_ns = result_mon.threshold_ns;
                got.timed_out    = result_mon.timed_out;
                if (expected_results.size() == 0)
                    report_mismatch("result with nothing pending, sample_ns",
                                    64'(got.sample_ns), '0);
                else
                begin
                    want = expected_results.pop_front();
                    checked_count++;
                    if (got.sample_ns !== want.sample_ns)
                        report_mismatch("sample_ns", 64'(got.sample_ns), 64'(want.sample_ns));
                    if (got.smoothed_ns !== want.smoothed_ns)
                        report_mismatch("smoothed_ns", 64'(got.smoothed_ns),
                                        64'(want.smoothed_ns));
                    if (got.deviation_ns !== want.deviation_ns)
                        report_mismatch("deviation_ns", 64'(got.deviation_ns),
                                        64'(want.deviation_ns));
                    if (got.threshold_ns !== want.threshold_ns)
                        report_mismatch("threshold_ns", 64'(got.threshold_ns),
                                        64'(want.threshold_ns));
                    if (got.timed_out !== want.timed_out)
                        report_mismatch("timed_out", 64'(got.timed_out), 64'(want.timed_out));
                end
            end
            if (sample_mon.valid && sample_mon.ready)
            begin
                predict_rtt(sample_mon.send_seconds, sample_mon.send_nanos,
                            sample_mon.recv_seconds, sample_mon.recv_nanos, want);
                expected_results.push_back(want);
            end
            outstanding <= expected_results.size();
        end
    end

endmodule

[sim/tb_top.sv]
// Top of the RTT estimator testbench: clock, reset, timestamp and gain stimulus,
// output back-pressure and the verdict. Depends on rtt_pkg, rtt_if.sv, the core
// and rtt_checker.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SEC_W  = rtt_pkg::SEC_BITS;
    localparam int NS_W   = rtt_pkg::NS_BITS;
    localparam int GAIN_W = rtt_pkg::GAIN_BITS;

    // index with no register behind it; the write must be accepted and ignored
    localparam logic [rtt_pkg::CFG_IDX_BITS-1:0] REG_SPARE = 8'd2;
    localparam longint NS_PER_S  = 1000000000;
    localparam int     HOLD_LEN  = 400;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    rtt_in_if  sample_ch ();
    rtt_cfg_if cfg_ch ();
    rtt_out_if result_ch ();

    int fail_count;
    int outstanding;
    int checked_count;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_requests = 0;
    int holds_served  = 0;
    int hold_left     = 0;
    int items_sent    = 0;
    int gain_settings = 0;
    logic [rtt_pkg::TIME_BITS_DEF-1:0] last_threshold = '0;

    rtt_estimator_timeout_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample_ch (sample_ch),
        .cfg_ch    (cfg_ch),
        .result_ch (result_ch)
    );

    rtt_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .sample_mon    (sample_ch),
        .cfg_mon       (cfg_ch),
        .result_mon    (result_ch),
        .fail_count    (fail_count),
        .outstanding   (outstanding),
        .checked_count (checked_count)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #2ms;
        $display("tb: failure");
        $finish;
    end

    // result back-pressure: random idling, plus a long hold-off on request
    always @(posedge clk)
    begin
        if (holds_served != hold_requests)
        begin
            holds_served = hold_requests;
            hold_left    = HOLD_LEN;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            result_ch.ready <= 1'b0;
        end
        else
            result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if (result_ch.valid && result_ch.ready)
            last_threshold <= result_ch.threshold_ns;
    end

    task automatic push_sample(input logic [SEC_W-1:0] ss, input logic [NS_W-1:0] sn,
                               input logic [SEC_W-1:0] rs, input logic [NS_W-1:0] rn);
        sample_ch.valid        <= 1'b1;
        sample_ch.send_seconds <= ss;
        sample_ch.send_nanos   <= sn;
        sample_ch.recv_seconds <= rs;
        sample_ch.recv_nanos   <= rn;
        do @(posedge clk); while (!sample_ch.ready);
        items_sent++;
        if ($urandom_range(99) < send_idle_pct)
        begin
            sample_ch.valid <= 1'b0;
            repeat ($urandom_range(6, 1)) @(posedge clk);
        end
    endtask

    // receive stamp = send stamp + delta ns, clamped at time zero
    task automatic push_rtt(input logic [SEC_W-1:0] ss, input logic [NS_W-1:0] sn,
                            input longint delta_ns);
        longint total;
        total = longint'(ss) * NS_PER_S + longint'(sn) + delta_ns;
        if (total < 0)
            total = 0;
        push_sample(ss, sn, 32'(total / NS_PER_S), 30'(total % NS_PER_S));
    endtask

    task automatic wait_drained();
        sample_ch.valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
    endtask

    task automatic write_reg(input logic [rtt_pkg::CFG_IDX_BITS-1:0] idx,
                             input logic [GAIN_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do @(posedge clk); while (!cfg_ch.ready);
    endtask

    task automatic set_gains(input logic [GAIN_W-1:0] alpha, input logic [GAIN_W-1:0] beta);
        write_reg(rtt_pkg::REG_ALPHA, alpha);
        write_reg(rtt_pkg::REG_BETA, beta);
        cfg_ch.valid <= 1'b0;
        gain_settings++;
    endtask

    task automatic push_random_item();
        logic [SEC_W-1:0] ss;
        logic [NS_W-1:0]  sn;
        int               pick;
        longint           delta;
        ss   = $urandom();
        sn   = 30'($urandom_range(999999999, 0));
        pick = $urandom_range(99);
        if (pick < 45)
            delta = longint'($urandom() >> $urandom_range(31, 0)) + 1;
        else if (pick < 55)
            delta = longint'({$urandom(), $urandom()} >> $urandom_range(63, 14));
        else if (pick < 70)
            delta = longint'(last_threshold) + int'($urandom_range(4)) - 2;
        else if (pick < 78)
            delta = 0;
        else if (pick < 88)
            delta = -(longint'($urandom() >> $urandom_range(31, 0)) + 1);
        else
        begin
            // raw fields, nanoseconds allowed past one second
            push_sample($urandom(), 30'($urandom()), $urandom(), 30'($urandom()));
            return;
        end
        push_rtt(ss, sn, delta);
    endtask

    initial
    begin
        sample_ch.valid        <= 1'b0;
        sample_ch.send_seconds <= '0;
        sample_ch.send_nanos   <= '0;
        sample_ch.recv_seconds <= '0;
        sample_ch.recv_nanos   <= '0;
        cfg_ch.valid           <= 1'b0;
        cfg_ch.index           <= '0;
        cfg_ch.data            <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part, reset gains, no estimate yet
        send_idle_pct <= 8;
        recv_idle_pct <= 45;
        push_rtt(100, 0, 0);                          // zero sample, zero threshold
        push_rtt(100, 500, -250);                     // negative sample
        push_sample(7, 30'h3FFFFFFF, 8, 0);           // oversized nanos, negative
        push_rtt(3, 999999999, 1);                    // first sample 1 ns across a borrow
        push_rtt(9, 10, 1);                           // deviation still zero
        push_rtt(0, 0, 0);                            // zero sample while threshold zero
        push_sample(7, 0, 7, 30'h3FFFFFFF);           // oversized nanos, positive
        push_rtt(5, 900000000, 200000000);            // borrow
        push_sample(0, 0, 32'hFFFFFFFF, 30'h3FFFFFFF); // saturates the sample
        push_sample(32'hFFFFFFFF, 30'h3FFFFFFF, 0, 0); // most negative
        push_rtt(0, 0, 1);                            // big error, threshold leaves saturation
        push_rtt(1, 0, 0);                            // zero sample, threshold set
        wait_drained();

        write_reg(REG_SPARE, 16'($urandom()));
        set_gains(16'hFFFF, 16'hFFFF);
        push_rtt(20, 0, 1000000);
        push_rtt(21, 0, 1500000);
        push_rtt(22, 0, 1000000);
        wait_drained();

        // frozen estimate: sample right at, below and above the threshold
        set_gains(16'h0000, 16'h0000);
        push_rtt(30, 0, longint'(last_threshold));
        push_rtt(31, 0, longint'(last_threshold) - 1);
        push_rtt(32, 0, longint'(last_threshold) + 1);
        wait_drained();

        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct <= (phase == 0) ? 8 : (phase == 1) ? 45 : 0;
            recv_idle_pct <= (phase == 0) ? 45 : (phase == 1) ? 8 : 0;
            for (int k = 0; k < 3; k++)
            begin
                wait_drained();
                if (k == 0)
                    set_gains(16'($urandom()), 16'($urandom()));
                else if (k == 1)
                    set_gains((phase == 0) ? 16'hFFFF :
                              (phase == 1) ? 16'h0000 : rtt_pkg::ALPHA_RESET,
                              (phase == 0) ? 16'h0000 :
                              (phase == 1) ? 16'hFFFF : rtt_pkg::BETA_RESET);
                else
                    set_gains(16'($urandom_range(4096, 1)), 16'($urandom_range(8192, 1)));
                for (int n = 0; n < 120; n++)
                begin
                    if (phase == 2 && k == 0 && n == 40)
                        hold_requests <= hold_requests + 1;
                    push_random_item();
                end
            end
        end

        wait_drained();
        repeat (30) @(posedge clk);
        $display("summary: %0d timestamp items, %0d results checked under %0d gain settings",
                 items_sent, checked_count, gain_settings);
        $display("summary: three idling mixes, one long output stall, %0d mismatches",
                 fail_count);
        if (fail_count == 0 && outstanding == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
